// ----- rtl/tmhs_pkg.sv -----
package tmhs_pkg;

	localparam int HEAP_CAP  = 32;
	localparam int IDX_W     = $clog2(HEAP_CAP);
	localparam int CNT_W     = IDX_W + 1;
	localparam int ID_W      = 8;
	localparam int ID_N      = 1 << ID_W;
	localparam int TIME_W    = 48;
	localparam int RES_DEPTH = 64;
	localparam int RES_AW    = $clog2(RES_DEPTH);
	localparam int KCNT_W    = $clog2(HEAP_CAP + 1);

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_BUSY      = 3'd2;
	localparam logic [2:0] ST_CANCELLED = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_EXPIRED   = 3'd5;
	localparam logic [2:0] ST_DONE      = 3'd6;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [TIME_W-1:0] expire_time;
		logic [TIME_W-1:0] repeat_interval;
		logic [ID_W-1:0]   timer_id;
		logic [TIME_W-1:0] now;
	} cmd_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] iv;
		logic [TIME_W-1:0] exp;
	} heap_ent_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] rid;
	} res_ent_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ID_W-1:0]   result_id;
		logic [TIME_W-1:0] next_deadline;
		logic              deadline_valid;
		logic              last;
	} res_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
	} eng_stat_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CAN_POS, S_REM_LD, S_UP_RD, S_UP_CMP, S_DN_L, S_DN_R, S_DN_CMP,
		S_WR_E, S_DONE_OP, S_TK_CHK, S_TK_EV, S_FIN, S_FIN2, S_EM_RD, S_EM_W
	} state_t;

endpackage

// ----- rtl/tmhs_ram.sv -----
module tmhs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end

endmodule

// ----- rtl/tmhs_front.sv -----
module tmhs_front import tmhs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  cmd_word_t in_word,
	output logic      q_valid,
	output cmd_word_t q_word,
	input  logic      q_pop
);

	cmd_word_t  buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_word   = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buf_q[wp_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, q_pop};
		end
	end

endmodule

// ----- rtl/tmhs_engine.sv -----
module tmhs_engine import tmhs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  cmd_word_t q_word,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output res_word_t out_word,
	output eng_stat_t stat
);

	state_t            st_q, st_d;
	cmd_word_t         c_q;
	logic [CNT_W-1:0]  count_q;
	logic [ID_W-1:0]   nid_q;
	logic [IDX_W-1:0]  pos_q;
	heap_ent_t         e_q, lft_q;
	logic              add_q;
	logic [KCNT_W-1:0] k_q;
	logic [RES_AW-1:0] nres_q, j_q;
	logic [TIME_W-1:0] dl_q;
	logic              dv_q, ov_q;
	res_word_t         ow_q;
	logic [ID_N-1:0]   live_q;

	logic              h_we;
	logic [IDX_W-1:0]  h_wa, h_ra;
	heap_ent_t         h_wd, h_rd;
	logic              p_we;
	logic [ID_W-1:0]   p_wa, p_ra;
	logic [IDX_W-1:0]  p_wd, p_rd;
	logic              r_we;
	res_ent_t          r_wd, r_rd;

	logic [CNT_W-1:0]  left, right, cnt_m1;
	logic [IDX_W-1:0]  parent;
	logic              up_less, lless, rbest, move, due, full, busy;
	logic [TIME_W-1:0] mexp;
	heap_ent_t         child;
	logic [IDX_W-1:0]  cidx;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] rearm;

	tmhs_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(HEAP_CAP)) u_heap (
		.clk(clk), .we(h_we), .wa(h_wa), .wd(h_wd), .ra(h_ra), .rd(h_rd)
	);
	tmhs_ram #(.WIDTH(IDX_W), .DEPTH(ID_N)) u_pos (
		.clk(clk), .we(p_we), .wa(p_wa), .wd(p_wd), .ra(p_ra), .rd(p_rd)
	);
	tmhs_ram #(.WIDTH($bits(res_ent_t)), .DEPTH(RES_DEPTH)) u_res (
		.clk(clk), .we(r_we), .wa(nres_q), .wd(r_wd), .ra(j_q), .rd(r_rd)
	);

	assign left    = {pos_q, 1'b1};
	assign right   = left + CNT_W'(1);
	assign parent  = (pos_q - IDX_W'(1)) >> 1;
	assign cnt_m1  = count_q - CNT_W'(1);
	assign up_less = e_q.exp < h_rd.exp;
	assign lless   = lft_q.exp < e_q.exp;
	assign mexp    = lless ? lft_q.exp : e_q.exp;
	assign rbest   = (right < count_q) && (h_rd.exp < mexp);
	assign move    = rbest || lless;
	assign child   = rbest ? h_rd : lft_q;
	assign cidx    = rbest ? right[IDX_W-1:0] : left[IDX_W-1:0];
	assign due     = h_rd.exp <= c_q.now;
	assign sum     = {1'b0, c_q.now} + {1'b0, h_rd.iv};
	assign rearm   = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	assign full    = count_q >= CNT_W'(HEAP_CAP);
	assign busy    = live_q[nid_q];
	assign q_pop   = (st_q == S_IDLE) && q_valid;

	assign out_valid  = ov_q;
	assign out_word   = ow_q;
	assign stat.count = count_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					case (q_word.cmd)
						CMD_ADD:    st_d = (full || busy) ? S_FIN : S_UP_RD;
						CMD_CANCEL: st_d = live_q[q_word.timer_id] ? S_CAN_POS : S_FIN;
						CMD_TICK:   st_d = S_TK_CHK;
						default:    st_d = S_FIN;
					endcase
				end
			end
			S_CAN_POS: st_d = S_REM_LD;
			S_REM_LD:  st_d = ({1'b0, pos_q} < cnt_m1) ? S_UP_RD : S_DONE_OP;
			S_UP_RD:   st_d = (pos_q == '0) ? (add_q ? S_WR_E : S_DN_L) : S_UP_CMP;
			S_UP_CMP:  st_d = up_less ? S_UP_RD : (add_q ? S_WR_E : S_DN_L);
			S_DN_L:    st_d = (left >= count_q) ? S_WR_E : S_DN_R;
			S_DN_R:    st_d = S_DN_CMP;
			S_DN_CMP:  st_d = move ? S_DN_L : S_WR_E;
			S_WR_E:    st_d = S_DONE_OP;
			S_DONE_OP: st_d = (c_q.cmd == CMD_TICK) ? S_TK_CHK : S_FIN;
			S_TK_CHK: begin
				st_d = (count_q == '0 || k_q == KCNT_W'(HEAP_CAP)) ? S_FIN : S_TK_EV;
			end
			S_TK_EV: begin
				if (!due) begin
					st_d = S_FIN;
				end else begin
					st_d = (h_rd.iv != '0) ? S_DN_L : S_REM_LD;
				end
			end
			S_FIN:   st_d = S_FIN2;
			S_FIN2:  st_d = S_EM_RD;
			S_EM_RD: st_d = S_EM_W;
			S_EM_W: begin
				if (ov_q && out_ready) begin
					st_d = ow_q.last ? S_IDLE : S_EM_RD;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		h_we = 1'b0;
		h_wa = pos_q;
		h_wd = e_q;
		h_ra = '0;
		p_we = 1'b0;
		p_wa = e_q.id;
		p_wd = pos_q;
		p_ra = q_word.timer_id;
		r_we = 1'b0;
		r_wd = '{status: ST_DONE, rid: '0};
		case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					case (q_word.cmd)
						CMD_ADD: begin
							r_we = 1'b1;
							r_wd = '{status: full ? ST_FULL : (busy ? ST_BUSY : ST_ADDED),
								rid: nid_q};
						end
						CMD_CANCEL: begin
							r_we = !live_q[q_word.timer_id];
							r_wd = '{status: ST_NOT_FOUND, rid: q_word.timer_id};
						end
						CMD_TICK: r_we = 1'b0;
						default:  r_we = 1'b1;
					endcase
				end
			end
			S_CAN_POS: begin
				h_ra = cnt_m1[IDX_W-1:0];
				r_we = 1'b1;
				r_wd = '{status: ST_CANCELLED, rid: c_q.timer_id};
			end
			S_UP_RD: h_ra = parent;
			S_UP_CMP: begin
				h_we = up_less;
				h_wd = h_rd;
				p_we = up_less;
				p_wa = h_rd.id;
			end
			S_DN_L: h_ra = left[IDX_W-1:0];
			S_DN_R: h_ra = right[IDX_W-1:0];
			S_DN_CMP: begin
				h_we = move;
				h_wd = child;
				p_we = move;
				p_wa = child.id;
			end
			S_WR_E: begin
				h_we = 1'b1;
				p_we = 1'b1;
			end
			S_TK_CHK: begin
				r_we = (count_q == '0 || k_q == KCNT_W'(HEAP_CAP));
			end
			S_TK_EV: begin
				h_ra = cnt_m1[IDX_W-1:0];
				r_we = 1'b1;
				r_wd = due ? res_ent_t'{status: ST_EXPIRED, rid: h_rd.id}
					: res_ent_t'{status: ST_DONE, rid: '0};
			end
			default: h_ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				c_q   <= q_word;
				e_q   <= '{id: nid_q, iv: q_word.repeat_interval, exp: q_word.expire_time};
				pos_q <= count_q[IDX_W-1:0];
			end
			S_CAN_POS: pos_q <= p_rd;
			S_REM_LD:  e_q <= h_rd;
			S_UP_CMP:  if (up_less) pos_q <= parent;
			S_DN_R:    lft_q <= h_rd;
			S_DN_CMP:  if (move) pos_q <= cidx;
			S_TK_EV: begin
				pos_q <= '0;
				e_q   <= '{id: h_rd.id, iv: h_rd.iv, exp: rearm};
			end
			S_FIN2:    dl_q <= (count_q != '0) ? h_rd.exp : '0;
			S_EM_RD:   dv_q <= (count_q != '0);
			S_EM_W: begin
				if (!ov_q) begin
					ow_q <= '{status: r_rd.status, result_id: r_rd.rid, next_deadline: dl_q,
						deadline_valid: dv_q, last: (j_q == nres_q - RES_AW'(1))};
				end
			end
			default: dl_q <= dl_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			count_q <= '0;
			nid_q   <= '0;
			live_q  <= '0;
			add_q   <= 1'b0;
			k_q     <= '0;
			nres_q  <= '0;
			j_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (r_we) begin
				nres_q <= nres_q + RES_AW'(1);
			end
			case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						j_q    <= '0;
						k_q    <= '0;
						add_q  <= (q_word.cmd == CMD_ADD);
						if (q_word.cmd == CMD_ADD) begin
							nid_q <= nid_q + ID_W'(1);
							if (!full && !busy) begin
								live_q[nid_q] <= 1'b1;
								count_q       <= count_q + CNT_W'(1);
							end
						end
					end
				end
				S_CAN_POS: live_q[c_q.timer_id] <= 1'b0;
				S_REM_LD:  count_q <= cnt_m1;
				S_TK_EV: begin
					if (due) begin
						k_q <= k_q + KCNT_W'(1);
						if (h_rd.iv == '0) begin
							live_q[h_rd.id] <= 1'b0;
						end
					end
				end
				S_EM_W: begin
					if (!ov_q) begin
						ov_q <= 1'b1;
					end else if (out_ready) begin
						ov_q <= 1'b0;
						j_q  <= j_q + RES_AW'(1);
						if (ow_q.last) begin
							nres_q <= '0;
						end
					end
				end
				default: ov_q <= ov_q;
			endcase
		end
	end

endmodule

// ----- rtl/timer_min_heap_scheduler.sv -----
// Timer queue: a binary min-heap of up to 32 timers keyed by 48-bit expiry time.
// Input channel s_*: one word per command. s_tuser carries cmd (add, cancel,
// tick); s_tdata carries expire_time, repeat_interval, timer_id and now.
// Output channel m_*: one or more words per command, m_tlast on the final one.
// m_tuser carries the status; m_tdata carries result_id, next_deadline and
// deadline_valid, the deadline being the heap root after the whole command.
// Commands pass through a two-word queue into a sequencer that walks the heap
// one level at a time over a heap memory with one read and one write port.
// A tick handles up to 32 expired timers.
// Results of a command are buffered and released only when it completes.
// Reset clears the heap, the id counter and all live flags; no clearing pass.
// While m_tready is low the sequencer holds its output word; the input queue
// keeps taking up to two more commands before s_tready drops.
module timer_min_heap_scheduler import tmhs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [151:0] s_tdata,  // expire_time, repeat_interval, timer_id, now
	input  logic [1:0]   s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // result_id, next_deadline, deadline_valid, zero pad
	output logic [2:0]   m_tuser,  // status
	output logic         m_tlast
);

	cmd_word_t in_word, q_word;
	logic      q_valid, q_pop;
	res_word_t ow;
	eng_stat_t stat;

	assign in_word = '{cmd: s_tuser, expire_time: s_tdata[47:0],
		repeat_interval: s_tdata[95:48], timer_id: s_tdata[103:96], now: s_tdata[151:104]};

	tmhs_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_word(in_word), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
	);

	tmhs_engine u_engine (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_word(ow), .stat(stat)
	);

	assign m_tdata = {7'd0, ow.deadline_valid, ow.next_deadline, ow.result_id};
	assign m_tuser = ow.status;
	assign m_tlast = ow.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(HEAP_CAP))
		else $error("heap count out of range");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= ST_DONE)
		else $error("bad status code");

	a_deadline_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !ow.deadline_valid) |-> ow.next_deadline == '0)
		else $error("deadline set on empty heap");

endmodule

// ----- bench/tb_timer_min_heap_scheduler.sv -----
module tb_timer_min_heap_scheduler;
	import tmhs_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct {
		logic [2:0]        status;
		logic [ID_W-1:0]   rid;
		logic [TIME_W-1:0] deadline;
		logic              armed;
		logic              last;
	} timer_word_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [151:0] s_tdata;  // expire_time, repeat_interval, timer_id, now
	logic [1:0]   s_tuser;  // cmd
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;  // result_id, next_deadline, deadline_valid, zero pad
	logic [2:0]   m_tuser;  // status
	logic         m_tlast;

	timer_min_heap_scheduler i_dut (.*);

	logic [TIME_W-1:0] hp_exp[HEAP_CAP];
	logic [TIME_W-1:0] hp_iv[HEAP_CAP];
	logic [ID_W-1:0]   hp_id[HEAP_CAP];
	int                slot_of[ID_N];
	bit                live[ID_N];
	int                hp_cnt;
	logic [ID_W-1:0]   id_ctr;
	timer_word_t       pending_q[$];
	int                errors;
	int                send_pct;
	int                recv_pct;
	logic [TIME_W-1:0] clock_ticks;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [TIME_W-1:0] rand_time();
		return TIME_W'({$urandom, $urandom});
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [TIME_W-1:0] te, ti;
		logic [ID_W-1:0] td;
		te = hp_exp[a]; ti = hp_iv[a]; td = hp_id[a];
		hp_exp[a] = hp_exp[b]; hp_iv[a] = hp_iv[b]; hp_id[a] = hp_id[b];
		hp_exp[b] = te; hp_iv[b] = ti; hp_id[b] = td;
		slot_of[hp_id[a]] = a;
		slot_of[hp_id[b]] = b;
	endfunction

	function automatic int sift_up(int p);
		int parent;
		while (p > 0) begin
			parent = (p - 1) / 2;
			if (hp_exp[p] < hp_exp[parent]) begin
				swap_slots(p, parent);
				p = parent;
			end else begin
				break;
			end
		end
		return p;
	endfunction

	function automatic void sift_down(int p);
		int l, r, best;
		forever begin
			l = p * 2 + 1;
			r = p * 2 + 2;
			best = p;
			if (l >= hp_cnt) break;
			if (hp_exp[l] < hp_exp[best]) best = l;
			if (r < hp_cnt && hp_exp[r] < hp_exp[best]) best = r;
			if (best == p) break;
			swap_slots(p, best);
			p = best;
		end
	endfunction

	function automatic void remove_slot(int p);
		int lp;
		if (hp_cnt == 0 || p >= hp_cnt) return;
		lp = hp_cnt - 1;
		live[hp_id[p]] = 1'b0;
		if (p != lp) begin
			hp_exp[p] = hp_exp[lp];
			hp_iv[p] = hp_iv[lp];
			hp_id[p] = hp_id[lp];
			slot_of[hp_id[p]] = p;
		end
		hp_cnt = lp;
		if (p < hp_cnt) sift_down(sift_up(p));
	endfunction

	function automatic void predict_timers(logic [1:0] cmd, logic [TIME_W-1:0] exp_t,
			logic [TIME_W-1:0] iv, logic [ID_W-1:0] tid, logic [TIME_W-1:0] now);
		timer_word_t w[$];
		timer_word_t t;
		logic [ID_W-1:0] id;
		logic [TIME_W:0] sum;
		int p;
		t.deadline = '0; t.armed = 1'b0; t.last = 1'b0;
		case (cmd)
			CMD_ADD: begin
				id = id_ctr;
				id_ctr = id_ctr + 1'b1;
				t.rid = id;
				if (hp_cnt >= HEAP_CAP) begin
					t.status = ST_FULL;
				end else if (live[id]) begin
					t.status = ST_BUSY;
				end else begin
					p = hp_cnt++;
					hp_exp[p] = exp_t; hp_iv[p] = iv; hp_id[p] = id;
					slot_of[id] = p;
					live[id] = 1'b1;
					void'(sift_up(p));
					t.status = ST_ADDED;
				end
				w = {w, t};
			end
			CMD_CANCEL: begin
				t.rid = tid;
				if (live[tid]) begin
					remove_slot(slot_of[tid]);
					t.status = ST_CANCELLED;
				end else begin
					t.status = ST_NOT_FOUND;
				end
				w = {w, t};
			end
			CMD_TICK: begin
				while (hp_cnt > 0 && hp_exp[0] <= now && w.size() < HEAP_CAP) begin
					t.status = ST_EXPIRED;
					t.rid = hp_id[0];
					w = {w, t};
					if (hp_iv[0] != '0) begin
						sum = now + hp_iv[0];
						hp_exp[0] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
						sift_down(0);
					end else begin
						remove_slot(0);
					end
				end
				t.status = ST_DONE; t.rid = '0;
				w = {w, t};
			end
			default: begin
				t.status = ST_DONE; t.rid = '0;
				w = {w, t};
			end
		endcase
		foreach (w[k]) begin
			w[k].armed = hp_cnt > 0;
			w[k].deadline = hp_cnt > 0 ? hp_exp[0] : '0;
			w[k].last = k == w.size() - 1;
			pending_q = {pending_q, w[k]};
		end
	endfunction

	task automatic send_cmd(logic [1:0] cmd, logic [TIME_W-1:0] exp_t,
			logic [TIME_W-1:0] iv, logic [ID_W-1:0] tid, logic [TIME_W-1:0] now);
		while ($urandom_range(99) < send_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {now, tid, iv, exp_t};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_timers(cmd, exp_t, iv, tid, now);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= $urandom_range(99) >= recv_pct;
		if (m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected word status=%0d", m_tuser);
				errors++;
			end else begin
				timer_word_t e;
				e = pending_q.pop_front();
				if (m_tuser !== e.status) begin
					$error("status exp %0d got %0d", e.status, m_tuser); errors++;
				end
				if (m_tdata[7:0] !== e.rid) begin
					$error("result_id exp %0d got %0d", e.rid, m_tdata[7:0]); errors++;
				end
				if (m_tdata[55:8] !== e.deadline) begin
					$error("next_deadline exp %0h got %0h", e.deadline, m_tdata[55:8]);
					errors++;
				end
				if (m_tdata[56] !== e.armed) begin
					$error("deadline_valid exp %0d got %0d", e.armed, m_tdata[56]); errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last exp %0d got %0d", e.last, m_tlast); errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_cmd(CMD_TICK, '0, '0, '0, '0);
		send_cmd(CMD_CANCEL, '0, '0, 8'hFF, '0);
		send_cmd(CMD_ADD, TIME_MAX, '0, '0, '0);
		send_cmd(CMD_ADD, '0, '0, '0, '0);
		send_cmd(CMD_ADD, 48'd100, 48'd10, '0, '0);
		send_cmd(CMD_ADD, 48'd50, 48'd7, '0, '0);
		send_cmd(CMD_CANCEL, '0, '0, 8'd2, '0);
		send_cmd(CMD_CANCEL, '0, '0, 8'd2, '0);
		send_cmd(CMD_TICK, '0, '0, '0, 48'd60);
		send_cmd(CMD_TICK, '0, '0, '0, 48'd200);
		send_cmd(CMD_NOP, TIME_MAX, TIME_MAX, 8'hFF, TIME_MAX);
		send_cmd(CMD_ADD, 48'd5, TIME_MAX, '0, '0);
		send_cmd(CMD_TICK, '0, '0, '0, 48'd10);
		send_cmd(CMD_TICK, '0, '0, '0, TIME_MAX);
		send_cmd(CMD_TICK, '0, '0, '0, TIME_MAX);
		for (int i = 0; i < ID_N; i++) begin
			if (live[i]) send_cmd(CMD_CANCEL, '0, '0, i[ID_W-1:0], '0);
		end
		drain();
	endtask

	task automatic test_full_and_busy();
		logic [ID_W-1:0] keep;
		keep = id_ctr;
		while (hp_cnt < HEAP_CAP) send_cmd(CMD_ADD, rand_time(), '0, '0, '0);
		while (id_ctr != keep) send_cmd(CMD_ADD, '0, '0, '0, '0);
		send_cmd(CMD_CANCEL, '0, '0, keep + 8'd1, '0);
		send_cmd(CMD_ADD, '0, '0, '0, '0);
		send_cmd(CMD_TICK, '0, '0, '0, TIME_MAX);
		drain();
	endtask

	task automatic test_random(int n);
		int r, k;
		logic [TIME_W-1:0] et, iv;
		logic [ID_W-1:0] id;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 45) begin
				et = $urandom_range(9) == 0 ? rand_time() : clock_ticks + $urandom_range(1000);
				k = $urandom_range(9);
				iv = k < 5 ? '0 : (k < 9 ? TIME_W'($urandom_range(500) + 1) : rand_time());
				send_cmd(CMD_ADD, et, iv, ID_W'($urandom), rand_time());
			end else if (r < 65) begin
				id = ID_W'($urandom);
				if (hp_cnt > 0 && $urandom_range(3) != 0) id = hp_id[$urandom_range(hp_cnt - 1)];
				send_cmd(CMD_CANCEL, rand_time(), rand_time(), id, rand_time());
			end else if (r < 92) begin
				clock_ticks = clock_ticks + $urandom_range(400);
				send_cmd(CMD_TICK, rand_time(), rand_time(), ID_W'($urandom), clock_ticks);
			end else if (r < 96) begin
				send_cmd(CMD_TICK, rand_time(), rand_time(), ID_W'($urandom), rand_time());
			end else begin
				send_cmd(CMD_NOP, rand_time(), rand_time(), ID_W'($urandom), rand_time());
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_ADD;
		m_tready = 1'b0;
		errors = 0;
		send_pct = 0;
		recv_pct = 0;
		hp_cnt = 0;
		id_ctr = '0;
		clock_ticks = '0;
		foreach (live[i]) live[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_and_busy();
		test_random(25);
		send_pct = 88;
		test_random(25);
		send_pct = 0; recv_pct = 88;
		test_random(25);
		send_pct = 36; recv_pct = 36;
		test_random(25);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
